### src/utf8_to_utf16_transcoder_assert.svh
// Assertion macros shared by the transcoder RTL files.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/u2u_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// Used by the decoder, the result queue and the top level; depends on nothing.
`default_nettype none

package u2u_pkg;

    localparam int          RESULT_DEPTH   = 2;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic        KIND_UNIT   = 1'b0;
    localparam logic        KIND_FINISH = 1'b1;

    localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [20:0] MAX_CODE     = 21'h10FFFF;
    localparam logic [20:0] PLANE1_BASE  = 21'h010000;
    localparam logic [5:0]  HIGH_SURR_HI = 6'b110110;
    localparam logic [5:0]  LOW_SURR_HI  = 6'b110111;

    typedef struct packed {
        logic [20:0] code_accum;
        logic [1:0]  bytes_left;
        logic [15:0] units_written;
        logic        halted;
    } state_t;

    // One queued entry holds every result of one byte: one unit, a
    // surrogate pair, or the finish report.
    typedef struct packed {
        logic        kind;
        logic        pair;
        logic [15:0] unit_first;
        logic [15:0] unit_second;
        logic [15:0] unit_count;
    } entry_t;

endpackage

`default_nettype wire

### src/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder, top level: string state, decoder and result queue.
// Depends on u2u_pkg, u2u_decode, u2u_result_queue and the assertion header.
//
// The block takes one UTF-8 byte per cycle while s_ready is high and sends
// UTF-16 code units, one per output item; a zero byte sends a finish item with
// the unit count and clears the string state. A byte that completes a code
// point above 0xFFFF sends a surrogate pair as two items, high surrogate first.
// Decoded results wait in a queue of RESULT_DEPTH entries, at most one entry per
// byte; s_ready is low only while that queue is full. A write to the capacity
// register (cfg_wr_data) acts at once and is meant for idle times only.
`default_nettype none
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder #(
    parameter int RESULT_DEPTH = u2u_pkg::RESULT_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [15:0]      m_code_unit,
    output logic [15:0]      m_unit_count,
    output logic             m_last_of_run
);

    u2u_pkg::state_t st_reg, st_next, st_decoded;
    logic [15:0]     capacity_reg;
    logic            accept;
    logic            dec_push;
    u2u_pkg::entry_t dec_entry;
    logic            q_full;
    u2u_pkg::entry_t head_entry;
    logic            head_second;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign st_next = accept ? st_decoded : st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            capacity_reg <= u2u_pkg::CAPACITY_RESET;
        end else begin
            st_reg <= st_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    u2u_decode u_decode (
        .st        (st_reg),
        .data_byte (s_data_byte),
        .capacity  (capacity_reg),
        .st_next   (st_decoded),
        .push      (dec_push),
        .entry     (dec_entry)
    );

    u2u_result_queue #(
        .DEPTH (RESULT_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (accept && dec_push),
        .push_entry  (dec_entry),
        .full        (q_full),
        .head_valid  (m_valid),
        .head_entry  (head_entry),
        .head_second (head_second),
        .pop         (m_ready)
    );

    assign m_result_kind = head_entry.kind;
    assign m_code_unit   = head_second ? head_entry.unit_second : head_entry.unit_first;
    assign m_unit_count  = head_entry.unit_count + {15'd0, head_second};
    assign m_last_of_run = !head_entry.pair || head_second;

    `U2U_ASSERT_NEXT(a_finish_clears, accept && (s_data_byte == 8'h00),
        st_reg == '0, "String state not cleared after the terminating byte.")
    `U2U_ASSERT_NOW(a_halted_silent, accept && st_reg.halted && (s_data_byte != 8'h00),
        !dec_push, "A halted string produced a result.")

endmodule

`default_nettype wire

### src/u2u_decode.sv
// Byte decoder of the transcoder: next string state and queued results.
// Purely combinational; depends on u2u_pkg.
`default_nettype none

module u2u_decode (
    input  wire u2u_pkg::state_t st,
    input  wire logic [7:0]      data_byte,
    input  wire logic [15:0]     capacity,
    output u2u_pkg::state_t      st_next,
    output logic                 push,
    output u2u_pkg::entry_t      entry
);

    logic        emit_en;
    logic [20:0] emit_cp;
    logic [20:0] cp;
    logic [20:0] offset;
    logic [20:0] acc_cont;

    assign acc_cont = {st.code_accum[14:0], data_byte[5:0]};

    always_comb begin
        st_next = st;
        push    = 1'b0;
        entry   = '0;
        emit_en = 1'b0;
        emit_cp = '0;
        cp      = '0;
        offset  = '0;

        if (data_byte == 8'h00) begin
            push             = 1'b1;
            entry.kind       = u2u_pkg::KIND_FINISH;
            entry.unit_count = st.units_written;
            st_next          = '0;
        end else if (!st.halted) begin
            if (st.bytes_left != 2'd0) begin
                st_next.code_accum = acc_cont;
                st_next.bytes_left = st.bytes_left - 2'd1;
                if (st.bytes_left == 2'd1) begin
                    emit_en = 1'b1;
                    emit_cp = acc_cont;
                end
            end else if (st.units_written >= capacity) begin
                st_next.halted = 1'b1;
            end else if (data_byte inside {[8'h01:8'h7F]}) begin
                emit_en = 1'b1;
                emit_cp = {13'd0, data_byte};
            end else if ((data_byte & 8'hE0) == 8'hC0) begin
                st_next.code_accum = {16'd0, data_byte[4:0]};
                st_next.bytes_left = 2'd1;
            end else if ((data_byte & 8'hF0) == 8'hE0) begin
                st_next.code_accum = {17'd0, data_byte[3:0]};
                st_next.bytes_left = 2'd2;
            end else if ((data_byte & 8'hF8) == 8'hF0) begin
                st_next.code_accum = {18'd0, data_byte[2:0]};
                st_next.bytes_left = 2'd3;
            end else begin
                emit_en = 1'b1;
                emit_cp = u2u_pkg::REPLACEMENT;
            end
        end

        if (emit_en) begin
            cp = (emit_cp > u2u_pkg::MAX_CODE) ? u2u_pkg::REPLACEMENT : emit_cp;
            if (cp[20:16] == 5'd0) begin
                if (st.units_written >= capacity) begin
                    st_next.halted = 1'b1;
                end else begin
                    push                  = 1'b1;
                    entry.kind            = u2u_pkg::KIND_UNIT;
                    entry.unit_first      = cp[15:0];
                    entry.unit_count      = st.units_written + 16'd1;
                    st_next.units_written = st.units_written + 16'd1;
                end
            end else if (({1'b0, st.units_written} + 17'd1) >= {1'b0, capacity}) begin
                st_next.halted = 1'b1;
            end else begin
                offset                = cp - u2u_pkg::PLANE1_BASE;
                push                  = 1'b1;
                entry.kind            = u2u_pkg::KIND_UNIT;
                entry.pair            = 1'b1;
                entry.unit_first      = {u2u_pkg::HIGH_SURR_HI, offset[19:10]};
                entry.unit_second     = {u2u_pkg::LOW_SURR_HI, offset[9:0]};
                entry.unit_count      = st.units_written + 16'd1;
                st_next.units_written = st.units_written + 16'd2;
            end
        end
    end

endmodule

`default_nettype wire

### src/u2u_result_queue.sv
// Result queue of the transcoder: holds per-byte entries and sends a
// surrogate pair as two items. Depends on u2u_pkg and the assertion header.
`default_nettype none
`include "utf8_to_utf16_transcoder_assert.svh"

module u2u_result_queue #(
    parameter int DEPTH = u2u_pkg::RESULT_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire u2u_pkg::entry_t push_entry,
    output logic                 full,
    output logic                 head_valid,
    output u2u_pkg::entry_t      head_entry,
    output logic                 head_second,
    input  wire logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2u_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic              retire;

    assign full        = (cnt_reg == FULL_CNT);
    assign head_valid  = (cnt_reg != '0);
    assign head_entry  = mem_reg[rd_ptr_reg];
    assign head_second = phase_reg;
    assign retire      = pop && head_valid && (!head_entry.pair || phase_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop && head_valid) begin
            phase_next = !retire;
        end
        if (retire) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(retire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `U2U_ASSERT_NOW(a_no_push_when_full, push, !full, "Result queue pushed while full.")
    `U2U_ASSERT_NOW(a_second_needs_pair, phase_reg, head_valid && head_entry.pair,
        "Second half pending without a queued pair.")

endmodule

`default_nettype wire

### tb/u2u_stream_checker.sv
// Checker for the UTF-8 to UTF-16 transcoder: watches the byte, result and register ports.
// Predicts the UTF-16 items of every accepted byte and compares them in order.
// Depends on u2u_pkg for the result kinds and code point constants.
`timescale 1ns / 1ps

module u2u_stream_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_result_kind,
    input  wire logic [15:0] m_code_unit,
    input  wire logic [15:0] m_unit_count,
    input  wire logic        m_last_of_run,
    output int               error_count,
    output int               pending_results
);

    typedef struct packed {
        logic        kind;
        logic [15:0] unit;
        logic [15:0] count;
        logic        last;
    } utf16_item_t;

    utf16_item_t expected_units[$];
    utf16_item_t head;

    logic [15:0] capacity;
    logic [20:0] accum;
    logic [1:0]  cont_left;
    logic [15:0] written;
    logic        stopped;
    int          errors;

    task automatic push_code(input logic [20:0] cp);
        logic [20:0] code;
        logic [20:0] offset;
        code = (cp > u2u_pkg::MAX_CODE) ? u2u_pkg::REPLACEMENT : cp;
        if (code <= 21'h00FFFF) begin
            if (written >= capacity) begin
                stopped = 1'b1;
            end else begin
                written = written + 16'd1;
                expected_units.push_back('{u2u_pkg::KIND_UNIT, code[15:0], written, 1'b1});
            end
        end else if ({1'b0, written} + 17'd1 >= {1'b0, capacity}) begin
            stopped = 1'b1;
        end else begin
            offset = code - u2u_pkg::PLANE1_BASE;
            written = written + 16'd1;
            expected_units.push_back('{u2u_pkg::KIND_UNIT,
                                       {u2u_pkg::HIGH_SURR_HI, offset[19:10]},
                                       written, 1'b0});
            written = written + 16'd1;
            expected_units.push_back('{u2u_pkg::KIND_UNIT,
                                       {u2u_pkg::LOW_SURR_HI, offset[9:0]},
                                       written, 1'b1});
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (b == 8'h00) begin
            expected_units.push_back('{u2u_pkg::KIND_FINISH, 16'h0000, written, 1'b1});
            accum = '0;
            cont_left = '0;
            written = '0;
            stopped = 1'b0;
        end else if (!stopped) begin
            if (cont_left != 2'd0) begin
                accum = {accum[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    push_code(accum);
                end
            end else if (written >= capacity) begin
                stopped = 1'b1;
            end else if (b[7] == 1'b0) begin
                push_code({13'd0, b});
            end else if (b[7:5] == 3'b110) begin
                accum = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                accum = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                accum = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end else begin
                push_code(u2u_pkg::REPLACEMENT);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            capacity = u2u_pkg::CAPACITY_RESET;
            accum = '0;
            cont_left = '0;
            written = '0;
            stopped = 1'b0;
            errors = 0;
            expected_units.delete();
        end else begin
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_units.size() == 0) begin
                    errors++;
                    $error("result_kind: no item expected, actual %0d (code_unit %h)",
                           m_result_kind, m_code_unit);
                end else begin
                    head = expected_units.pop_front();
                    if (m_result_kind !== head.kind) begin
                        errors++;
                        $error("result_kind: expected %0d, actual %0d", head.kind,
                               m_result_kind);
                    end
                    if (m_code_unit !== head.unit) begin
                        errors++;
                        $error("code_unit: expected %h, actual %h", head.unit, m_code_unit);
                    end
                    if (m_unit_count !== head.count) begin
                        errors++;
                        $error("unit_count: expected %0d, actual %0d", head.count,
                               m_unit_count);
                    end
                    if (m_last_of_run !== head.last) begin
                        errors++;
                        $error("last_of_run: expected %0d, actual %0d", head.last,
                               m_last_of_run);
                    end
                end
            end
        end
        error_count <= errors;
        pending_results <= expected_units.size();
    end

endmodule

### tb/tb.sv
// Top of the transcoder testbench: clock, reset, byte stimulus, capacity writes and verdict.
// Depends on the transcoder RTL, u2u_pkg and the u2u_stream_checker module.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 100;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 110;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = 16'h0000;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_result_kind;
    logic [15:0] m_code_unit;
    logic [15:0] m_unit_count;
    logic        m_last_of_run;

    int error_count;
    int pending_results;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    bit idle_enable   = 1'b1;
    bit long_hold_req = 1'b0;

    utf8_to_utf16_transcoder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_kind(m_result_kind),
        .m_code_unit  (m_code_unit),
        .m_unit_count (m_unit_count),
        .m_last_of_run(m_last_of_run)
    );

    u2u_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_code_unit    (m_code_unit),
        .m_unit_count   (m_unit_count),
        .m_last_of_run  (m_last_of_run),
        .error_count    (error_count),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold so the block backs up.
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_char(input int len, input logic [20:0] cp);
        case (len)
            1: send_byte({1'b0, cp[6:0]});
            2: begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            3: begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default: begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int stop_at;
        int n;
        int sel;
        logic [15:0] cap;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset capacity.
        send_byte(8'h41);
        send_byte(8'h7F);
        send_char(2, 21'h0000E9);
        send_char(3, 21'h0020AC);
        send_char(4, 21'h01F600);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hF8);
        send_byte(8'hC3);
        send_byte(8'hE2);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'h00);

        // No room at all: the first lead byte halts the string.
        set_capacity(16'd0);
        send_byte(8'h41);
        send_byte(8'h00);

        // A surrogate pair that does not fit, then a halted string.
        set_capacity(16'd2);
        send_byte(8'h41);
        send_char(4, 21'h01F600);
        send_byte(8'h42);
        send_byte(8'h00);

        // Capacity lowered while a two-byte sequence is open.
        set_capacity(16'd3);
        send_byte(8'h41);
        send_byte(8'hC3);
        set_capacity(16'd1);
        send_byte(8'hA9);
        send_byte(8'h00);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: cap = 16'hFFFF;
                1: cap = 16'd0;
                2: cap = 16'd1;
                3: cap = 16'd2;
                PHASES - 1: cap = 16'hFFFF;
                default: cap = (phase % 2 == 0) ? 16'($urandom_range(2, 12))
                                                : 16'($urandom_range(0, 65535));
            endcase
            set_capacity(cap);
            if (phase == 0) begin
                long_hold_req = 1'b1;
            end
            if (phase == PHASES - 1) begin
                idle_enable = 1'b0;
            end
            stop_at = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < stop_at) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    n = $urandom_range(0, 6);
                    repeat (n) send_char($urandom_range(1, 4), 21'($urandom));
                    send_byte(8'h00);
                end else if (sel < 9) begin
                    send_byte(8'($urandom_range(1, 255)));
                end else begin
                    send_byte(8'($urandom_range(8'hC0, 8'hF7)));
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte({2'b10, 6'($urandom)});
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        send_byte(8'h00);
                    end
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/u2u_pkg.sv
src/u2u_decode.sv
src/u2u_result_queue.sv
src/utf8_to_utf16_transcoder.sv
tb/u2u_stream_checker.sv
tb/tb.sv
